// ----- sv/wsd_pkg.sv -----
package wsd_pkg;

    // Header decoding phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_LEN     = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // Length codes of the second header byte
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Byte counts of the extended length and the masking key
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    // One received byte with its frame start flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_data;
        logic       last_of_frame;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic       was_masked;
    } t_result;

endpackage

// ----- sv/wsd_if.sv -----
// Receive byte channel
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// Unmasked payload channel
interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_data;
    logic       last_of_frame;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       was_masked;

    modport source (output valid, output payload_byte, output has_data,
                    output last_of_frame, output frame_opcode,
                    output final_fragment, output was_masked, input ready);
    modport sink   (input valid, input payload_byte, input has_data,
                    input last_of_frame, input frame_opcode,
                    input final_fragment, input was_masked, output ready);
endinterface

// ----- sv/wsd_in_reg.sv -----
module wsd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wsd_in_if.sink            i_in,
    input  logic              i_take,
    output logic              o_valid,
    output wsd_pkg::t_in_item o_item
);

    logic              r_valid;
    wsd_pkg::t_in_item r_item;

    // Accept when empty or when the held byte moves on this cycle
    assign i_in.ready = !r_valid || i_take;

    // Hold the control bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Capture the byte on a transfer
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte   <= i_in.data_byte;
            r_item.frame_start <= i_in.frame_start;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- sv/wsd_parser.sv -----
module wsd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  wsd_pkg::t_in_item i_item,
    output logic              o_emit,
    output wsd_pkg::t_result  o_result
);

    wsd_pkg::t_phase r_phase,  n_phase;
    logic [3:0]      r_len_left, n_len_left;
    logic [2:0]      r_key_left, n_key_left;
    logic [63:0]     r_remain,   n_remain;
    logic [31:0]     r_mask_word, n_mask_word;
    logic [1:0]      r_key_pos,  n_key_pos;
    logic [3:0]      r_opcode,   n_opcode;
    logic            r_fin,      n_fin;
    logic            r_masked,   n_masked;

    logic [7:0]      key_byte;
    logic [6:0]      len7;
    logic [7:0]      b;
    logic            hdr_done;

    assign b    = i_item.data_byte;
    assign len7 = b[6:0];

    // Pick the key byte for the current payload position
    always_comb begin
        case (r_key_pos)
            2'd0:    key_byte = r_mask_word[31:24];
            2'd1:    key_byte = r_mask_word[23:16];
            2'd2:    key_byte = r_mask_word[15:8];
            default: key_byte = r_mask_word[7:0];
        endcase
    end

    // Decode one byte: advance the header state or unmask a payload byte
    always_comb begin
        n_phase     = r_phase;
        n_len_left  = r_len_left;
        n_key_left  = r_key_left;
        n_remain    = r_remain;
        n_mask_word = r_mask_word;
        n_key_pos   = r_key_pos;
        n_opcode    = r_opcode;
        n_fin       = r_fin;
        n_masked    = r_masked;
        hdr_done    = 1'b0;
        o_emit      = 1'b0;
        o_result    = '0;

        if (i_item.frame_start) begin
            n_opcode    = b[3:0];
            n_fin       = b[7];
            n_masked    = 1'b0;
            n_len_left  = '0;
            n_key_left  = '0;
            n_remain    = '0;
            n_mask_word = '0;
            n_key_pos   = '0;
            n_phase     = wsd_pkg::PH_LEN;
        end else begin
            case (r_phase)
                wsd_pkg::PH_LEN: begin
                    n_masked = b[7];
                    n_remain = '0;
                    if (len7 == wsd_pkg::LEN7_EXT16) begin
                        n_len_left = wsd_pkg::EXT16_BYTES;
                        n_phase    = wsd_pkg::PH_EXTLEN;
                    end else if (len7 == wsd_pkg::LEN7_EXT64) begin
                        n_len_left = wsd_pkg::EXT64_BYTES;
                        n_phase    = wsd_pkg::PH_EXTLEN;
                    end else begin
                        n_remain = {57'd0, len7};
                        if (n_masked) begin
                            n_key_left = wsd_pkg::KEY_BYTES;
                            n_phase    = wsd_pkg::PH_KEY;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                wsd_pkg::PH_EXTLEN: begin
                    n_remain   = {r_remain[55:0], b};
                    n_len_left = r_len_left - 4'd1;
                    if (n_len_left == 4'd0) begin
                        if (r_masked) begin
                            n_key_left = wsd_pkg::KEY_BYTES;
                            n_phase    = wsd_pkg::PH_KEY;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                wsd_pkg::PH_KEY: begin
                    n_mask_word = {r_mask_word[23:0], b};
                    n_key_left  = r_key_left - 3'd1;
                    if (n_key_left == 3'd0) begin
                        hdr_done = 1'b1;
                    end
                end
                wsd_pkg::PH_PAYLOAD: begin
                    o_emit                 = 1'b1;
                    o_result.payload_byte  = r_masked ? (b ^ key_byte) : b;
                    o_result.has_data      = 1'b1;
                    o_result.last_of_frame = (r_remain == 64'd1);
                    n_remain               = r_remain - 64'd1;
                    n_key_pos              = r_key_pos + 2'd1;
                    if (r_remain == 64'd1) begin
                        n_phase = wsd_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = wsd_pkg::PH_IDLE;
                end
            endcase

            // Header complete: start the payload or flag an empty frame
            if (hdr_done) begin
                n_key_pos = '0;
                if (n_remain == 64'd0) begin
                    n_phase                = wsd_pkg::PH_IDLE;
                    o_emit                 = 1'b1;
                    o_result.last_of_frame = 1'b1;
                end else begin
                    n_phase = wsd_pkg::PH_PAYLOAD;
                end
            end
        end

        o_result.frame_opcode   = n_opcode;
        o_result.final_fragment = n_fin;
        o_result.was_masked     = n_masked;
    end

    // Advance the frame state when a byte is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wsd_pkg::PH_IDLE;
            r_len_left  <= '0;
            r_key_left  <= '0;
            r_remain    <= '0;
            r_mask_word <= '0;
            r_key_pos   <= '0;
            r_opcode    <= '0;
            r_fin       <= 1'b0;
            r_masked    <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_len_left  <= n_len_left;
            r_key_left  <= n_key_left;
            r_remain    <= n_remain;
            r_mask_word <= n_mask_word;
            r_key_pos   <= n_key_pos;
            r_opcode    <= n_opcode;
            r_fin       <= n_fin;
            r_masked    <= n_masked;
        end
    end

endmodule

// ----- sv/wsd_out_reg.sv -----
module wsd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsd_pkg::t_result i_result,
    output logic             o_free,
    wsd_out_if.source        o_out
);

    logic             r_valid;
    wsd_pkg::t_result r_result;

    // Slot is free when empty or drained this cycle
    assign o_free = !r_valid || o_out.ready;

    // Hold the valid flag until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Capture a new result
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.payload_byte   = r_result.payload_byte;
    assign o_out.has_data       = r_result.has_data;
    assign o_out.last_of_frame  = r_result.last_of_frame;
    assign o_out.frame_opcode   = r_result.frame_opcode;
    assign o_out.final_fragment = r_result.final_fragment;
    assign o_out.was_masked     = r_result.was_masked;

endmodule

// ----- sv/websocket_frame_deframer_unit.sv -----
// WebSocket frame deframer, receive side.
// i_in carries one received byte per transfer; frame_start marks the first
// header byte of a frame and restarts header decoding at any time.
// o_out carries unmasked payload bytes tagged with the frame's opcode, FIN
// and mask bits; last_of_frame marks the final byte. A zero-length frame
// gives a single result with has_data low and last_of_frame high.
// Header bytes, and bytes outside a frame, give no result.
// Path: a byte transferred in sits in the input register while the decode
// runs, and its result loads the output register when that register is free.
// Throughput: one byte per cycle while o_out does not stall, set by the
// single decode stage between the two registers.
// When o_out stalls, the output register holds its result and the input
// register still takes one more byte; bytes that give no result keep
// flowing through the decoder while the output waits.
// Reset (synchronous, active low) empties both registers and returns the
// decoder to idle, waiting for a start byte.
module websocket_frame_deframer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsd_in_if.sink    i_in,
    wsd_out_if.source o_out
);

    logic              in_valid;
    wsd_pkg::t_in_item in_item;
    logic              emit;
    wsd_pkg::t_result  result;
    logic              out_free;
    logic              fire;

    // Process the held byte unless its result has nowhere to go
    assign fire = in_valid && (!emit || out_free);

    wsd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    wsd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (in_item),
        .o_emit   (emit),
        .o_result (result)
    );

    wsd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && emit),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

// ----- sv/wsd_checker.sv -----
module wsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_payload_byte,
    input logic       i_has_data,
    input logic       i_last_of_frame,
    input logic [3:0] i_frame_opcode
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_payload_byte)
            && $stable(i_frame_opcode) && $stable(i_last_of_frame))
        else $error("stalled result changed");

    // Empty-frame marker carries a zero byte and ends the frame
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_data |-> i_payload_byte == 8'd0 && i_last_of_frame)
        else $error("malformed empty-frame marker");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_payload_byte  (o_out.payload_byte),
    .i_has_data      (o_out.has_data),
    .i_last_of_frame (o_out.last_of_frame),
    .i_frame_opcode  (o_out.frame_opcode)
);
